@@ rtl/core/xsuf_pkg.sv @@
// ----------------------------------------------------------------------------
// xsuf_pkg
// Shared types and constants for the xorshift uniform float source.
// ----------------------------------------------------------------------------
package xsuf_pkg;

	localparam logic [63:0] GOLDEN_SEED = 64'h9E3779B97F4A7C15;
	localparam int unsigned SHIFT_A = 13;
	localparam int unsigned SHIFT_B = 7;
	localparam int unsigned SHIFT_C = 17;
	localparam int unsigned DROP_BITS = 11;
	localparam int unsigned MAG_W = 53;
	localparam int unsigned POS_W = 6;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_GEN  = 1'b1
	} action_t;

	typedef struct packed {
		logic             negative;
		logic [MAG_W-1:0] mag;
	} sample_req_t;

endpackage

@@ rtl/core/xsuf_front.sv @@
// ----------------------------------------------------------------------------
// xsuf_front
// Accepts items, holds and advances the generator state, and emits the
// signed magnitude of each sample into the queue.
// ----------------------------------------------------------------------------
module xsuf_front import xsuf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [63:0]       seed,
	output logic              req_valid,
	input  logic              req_ready,
	output sample_req_t       req
);

	logic [63:0] state_q;
	logic [63:0] t1, t2, nxt;
	logic [MAG_W-1:0] m;
	logic accept;

	always_comb begin
		t1 = state_q ^ (state_q << SHIFT_A);
		t2 = t1 ^ (t1 >> SHIFT_B);
		nxt = t2 ^ (t2 << SHIFT_C);
		m = nxt[63:DROP_BITS];
	end

	assign in_ready  = req_ready;
	assign req_valid = in_valid && (action == ACT_GEN);
	assign accept    = in_valid && in_ready;
	assign req.negative = ~m[MAG_W-1];
	assign req.mag = m[MAG_W-1] ? {1'b0, m[MAG_W-2:0]} : ({1'b1, {(MAG_W-1){1'b0}}} - m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GOLDEN_SEED;
		end else if (accept) begin
			if (action == ACT_GEN) state_q <= nxt;
			else state_q <= (seed == 64'd0) ? GOLDEN_SEED : seed;
		end
	end

endmodule

@@ rtl/core/xsuf_queue.sv @@
// ----------------------------------------------------------------------------
// xsuf_queue
// Two-entry queue between front and back; full rate while the back side reads, with registered ready.
// ----------------------------------------------------------------------------
module xsuf_queue import xsuf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_valid,
	output logic        wr_ready,
	input  sample_req_t wr_data,
	output logic        rd_valid,
	input  logic        rd_ready,
	output sample_req_t rd_data
);

	sample_req_t mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

@@ rtl/core/xsuf_back.sv @@
// ----------------------------------------------------------------------------
// xsuf_back
// Converts sign and magnitude to binary32 with round to nearest even.
// Stage 1 finds the leading one; stage 2 normalizes, rounds and packs.
// ----------------------------------------------------------------------------
module xsuf_back import xsuf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  sample_req_t req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sample_bits
);

	logic             v_s1, v_s2;
	logic             adv_s1, adv_s2;
	logic             neg_s1;
	logic [MAG_W-1:0] mag_s1;
	logic [POS_W-1:0] top_s1;
	logic             zero_s1;
	logic [31:0]      bits_s2;
	logic [POS_W-1:0] top_c;
	logic [MAG_W-1:0] norm;
	logic [24:0]      mant;
	logic [28:0]      rest;
	logic             rnd;
	logic [7:0]       biased;
	logic [31:0]      packed_c;

	assign adv_s2 = !v_s2 || out_ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign req_ready = adv_s1;
	assign out_valid = v_s2;
	assign sample_bits = bits_s2;

	always_comb begin
		top_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (req.mag[i]) top_c = POS_W'(i);
		end
	end

	always_comb begin
		norm = mag_s1 << (POS_W'(MAG_W - 1) - top_s1);
		mant = {1'b0, norm[MAG_W-1:MAG_W-24]};
		rest = norm[MAG_W-25:0];
		rnd  = rest[28] && ((rest[27:0] != '0) || mant[0]);
		mant = mant + {24'd0, rnd};
		biased = 8'(top_s1) + 8'd75;
		if (mant[24]) biased = biased + 8'd1;
		packed_c = {neg_s1, biased, mant[24] ? mant[23:1] : mant[22:0]};
		if (zero_s1) packed_c = 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= req_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			neg_s1  <= req.negative;
			mag_s1  <= req.mag;
			top_s1  <= top_c;
			zero_s1 <= (req.mag == '0);
		end
		if (adv_s2) bits_s2 <= packed_c;
	end

endmodule

@@ rtl/core/xorshift_uniform_float_source.sv @@
// ----------------------------------------------------------------------------
// xorshift_uniform_float_source
// Generate transactions pass through the queue and the 2 back stages to the
// sample, and are held there while out_ready is low.
// Throughput: one transaction per cycle while the queue has room.
// Load transactions update the state and produce no sample.
// Reset: asynchronous, state returns to 0x9E3779B97F4A7C15, pipeline empties.
// ----------------------------------------------------------------------------
module xorshift_uniform_float_source import xsuf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [63:0] seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sample_bits
);

	logic        f_valid, f_ready, q_valid, q_ready;
	sample_req_t f_data, q_data;

	xsuf_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .seed,
		.req_valid(f_valid), .req_ready(f_ready), .req(f_data)
	);

	xsuf_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);

	xsuf_back u_back (
		.clk, .arst_n,
		.req_valid(q_valid), .req_ready(q_ready), .req(q_data),
		.out_valid, .out_ready, .sample_bits
	);

endmodule
